>>> src/palcc_pkg.sv
// Shared types, constants and color tables of the palette color cycler.
package palcc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SLOW_PERIOD   = 2'd0;
  localparam logic [1:0] REG_MEDIUM_PERIOD = 2'd1;
  localparam logic [1:0] REG_FAST_PERIOD   = 2'd2;
  localparam logic [1:0] REG_BLINK_PERIOD  = 2'd3;

  localparam int NUM_TIMERS   = 4;
  localparam int PERIOD_WIDTH = 16;

  localparam logic [PERIOD_WIDTH-1:0] SLOW_PERIOD_RESET   = 16'd400;
  localparam logic [PERIOD_WIDTH-1:0] MEDIUM_PERIOD_RESET = 16'd284;
  localparam logic [PERIOD_WIDTH-1:0] FAST_PERIOD_RESET   = 16'd200;
  localparam logic [PERIOD_WIDTH-1:0] BLINK_PERIOD_RESET  = 16'd66;

  // Blink red triangle wave
  localparam logic [7:0] BLINK_TOP        = 8'd60;
  localparam logic [7:0] BLINK_STEP_RESET = 8'd252;

  // Lowest and highest palette entries that are written
  localparam logic [7:0] INDEX_LOW  = 8'd229;
  localparam logic [7:0] INDEX_HIGH = 8'd254;

  // Queue between the timer front and the write sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // Which timers fired on one time transaction
  typedef struct packed {
    logic slow;
    logic mid;
    logic fast;
    logic blink;
  } due_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Color groups in emission order
  typedef enum logic [2:0] {
    GRP_SLIME     = 3'd0,
    GRP_SHORE     = 3'd1,
    GRP_SLOW_FIRE = 3'd2,
    GRP_FAST_FIRE = 3'd3,
    GRP_MONITOR   = 3'd4,
    GRP_BLINK     = 3'd5
  } group_t;

  function automatic logic [2:0] group_size(group_t grp);
    logic [2:0] s;
    case (grp)
      GRP_SLIME:     s = 3'd4;
      GRP_SHORE:     s = 3'd6;
      GRP_SLOW_FIRE: s = 3'd5;
      GRP_FAST_FIRE: s = 3'd5;
      GRP_MONITOR:   s = 3'd5;
      GRP_BLINK:     s = 3'd1;
      default:       s = 3'd1;
    endcase
    return s;
  endfunction

  // Highest palette entry of a group; it is written first
  function automatic logic [7:0] group_top(group_t grp);
    logic [7:0] t;
    case (grp)
      GRP_SLIME:     t = 8'd232;
      GRP_SHORE:     t = 8'd253;
      GRP_SLOW_FIRE: t = 8'd242;
      GRP_FAST_FIRE: t = 8'd247;
      GRP_MONITOR:   t = 8'd237;
      GRP_BLINK:     t = 8'd254;
      default:       t = 8'd254;
    endcase
    return t;
  endfunction

  // Fixed color tables, addressed by group and color slot
  function automatic rgb_t rom_color(group_t grp, logic [2:0] w);
    rgb_t c;
    c = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    case (grp)
      GRP_SLIME: begin
        case (w)
          3'd0:    c = '{8'd0,  8'd108, 8'd0};
          3'd1:    c = '{8'd11, 8'd115, 8'd7};
          3'd2:    c = '{8'd27, 8'd123, 8'd15};
          3'd3:    c = '{8'd43, 8'd131, 8'd27};
          default: c = '{8'd0,  8'd108, 8'd0};
        endcase
      end
      GRP_SHORE: begin
        case (w)
          3'd0:    c = '{8'd83, 8'd63, 8'd43};
          3'd1:    c = '{8'd75, 8'd59, 8'd43};
          3'd2:    c = '{8'd67, 8'd55, 8'd39};
          3'd3:    c = '{8'd63, 8'd51, 8'd39};
          3'd4:    c = '{8'd55, 8'd47, 8'd35};
          3'd5:    c = '{8'd51, 8'd43, 8'd35};
          default: c = '{8'd83, 8'd63, 8'd43};
        endcase
      end
      GRP_SLOW_FIRE: begin
        case (w)
          3'd0:    c = '{8'd255, 8'd0,   8'd0};
          3'd1:    c = '{8'd215, 8'd0,   8'd0};
          3'd2:    c = '{8'd147, 8'd43,  8'd11};
          3'd3:    c = '{8'd255, 8'd119, 8'd0};
          3'd4:    c = '{8'd255, 8'd59,  8'd0};
          default: c = '{8'd255, 8'd0,   8'd0};
        endcase
      end
      GRP_FAST_FIRE: begin
        case (w)
          3'd0:    c = '{8'd71,  8'd0, 8'd0};
          3'd1:    c = '{8'd123, 8'd0, 8'd0};
          3'd2:    c = '{8'd179, 8'd0, 8'd0};
          3'd3:    c = '{8'd123, 8'd0, 8'd0};
          3'd4:    c = '{8'd71,  8'd0, 8'd0};
          default: c = '{8'd71,  8'd0, 8'd0};
        endcase
      end
      GRP_MONITOR: begin
        case (w)
          3'd0:    c = '{8'd107, 8'd107, 8'd111};
          3'd1:    c = '{8'd99,  8'd103, 8'd127};
          3'd2:    c = '{8'd87,  8'd107, 8'd143};
          3'd3:    c = '{8'd0,   8'd147, 8'd163};
          3'd4:    c = '{8'd107, 8'd187, 8'd255};
          default: c = '{8'd107, 8'd107, 8'd111};
        endcase
      end
      default: c = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

>>> src/palcc_front.sv
// Timer front: configuration registers, last-fire times and due detection.
module palcc_front #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [palcc_pkg::PERIOD_WIDTH-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    now_time,
  input  palcc_pkg::q_status_t           q_status,
  output logic                           q_push,
  output palcc_pkg::due_t                q_wdata
);
  import palcc_pkg::*;

  logic [PERIOD_WIDTH-1:0] period [NUM_TIMERS];
  logic [TIME_WIDTH-1:0]   last_fire [NUM_TIMERS];
  logic [TIME_WIDTH-1:0]   now_ext;
  logic [NUM_TIMERS-1:0]   due;
  logic                    accept;

  // Take a time transaction whenever the queue has room
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign now_ext  = TIME_WIDTH'(now_time);

  // Compare the wrap-safe elapsed time of each timer to its period
  always_comb begin
    for (int k = 0; k < NUM_TIMERS; k++) begin
      due[k] = (now_ext - last_fire[k]) >= TIME_WIDTH'(period[k]);
    end
  end

  assign q_wdata = '{slow:  due[REG_SLOW_PERIOD],
                     mid:   due[REG_MEDIUM_PERIOD],
                     fast:  due[REG_FAST_PERIOD],
                     blink: due[REG_BLINK_PERIOD]};
  assign q_push  = accept && (|due);

  // Hold the period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period[REG_SLOW_PERIOD]   <= SLOW_PERIOD_RESET;
      period[REG_MEDIUM_PERIOD] <= MEDIUM_PERIOD_RESET;
      period[REG_FAST_PERIOD]   <= FAST_PERIOD_RESET;
      period[REG_BLINK_PERIOD]  <= BLINK_PERIOD_RESET;
    end else if (cfg_write) begin
      period[cfg_index] <= cfg_data;
    end
  end

  // Record the fire time of every timer that is due
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        last_fire[k] <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        if (due[k]) begin
          last_fire[k] <= now_ext;
        end
      end
    end
  end

endmodule

>>> src/palcc_queue.sv
// Short queue of due masks between the timer front and the write sequencer.
module palcc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  palcc_pkg::due_t      wdata,
  input  logic                 pop,
  output palcc_pkg::due_t      rdata,
  output palcc_pkg::q_status_t status
);
  import palcc_pkg::*;

  due_t                  entry [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign status.full  = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = entry[rd_ptr];

  // Store the pushed mask
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/palcc_back.sv
// Write sequencer: walks due groups, one palette write per cycle unless stalled.
module palcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  palcc_pkg::q_status_t q_status,
  input  palcc_pkg::due_t      q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           palette_index,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic                 last
);
  import palcc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t     state;
  due_t       mask;
  group_t     grp;
  logic [2:0] slot;
  logic [2:0] w;

  logic [1:0] slime_phase;
  logic [2:0] shore_phase;
  logic [2:0] slow_fire_phase;
  logic [2:0] fast_fire_phase;
  logic [2:0] monitor_phase;
  logic [7:0] blink_level;
  logic [7:0] blink_step;

  logic       advance;
  logic [2:0] size;
  logic       group_done;
  logic       nxt_found;
  group_t     nxt_grp;
  group_t     first_grp;
  rgb_t       color;
  logic [7:0] step_n;
  logic [7:0] level_n;

  function automatic logic group_en(due_t m, group_t g);
    logic e;
    case (g)
      GRP_SLIME, GRP_SHORE, GRP_SLOW_FIRE: e = m.slow;
      GRP_FAST_FIRE:                       e = m.mid;
      GRP_MONITOR:                         e = m.fast;
      GRP_BLINK:                           e = m.blink;
      default:                             e = 1'b0;
    endcase
    return e;
  endfunction

  function automatic group_t first_group(due_t m);
    group_t g;
    if (m.slow) begin
      g = GRP_SLIME;
    end else if (m.mid) begin
      g = GRP_FAST_FIRE;
    end else if (m.fast) begin
      g = GRP_MONITOR;
    end else begin
      g = GRP_BLINK;
    end
    return g;
  endfunction

  function automatic logic [2:0] wrap_next(logic [2:0] p, logic [2:0] s);
    return (p >= s - 3'd1) ? 3'd0 : p + 3'd1;
  endfunction

  // First color slot of a group: its phase, or zero when out of range
  function automatic logic [2:0] start_slot(group_t g, logic [1:0] p_slime,
                                            logic [2:0] p_shore, logic [2:0] p_slow,
                                            logic [2:0] p_fast, logic [2:0] p_mon);
    logic [2:0] p;
    case (g)
      GRP_SLIME:     p = {1'b0, p_slime};
      GRP_SHORE:     p = p_shore;
      GRP_SLOW_FIRE: p = p_slow;
      GRP_FAST_FIRE: p = p_fast;
      GRP_MONITOR:   p = p_mon;
      default:       p = 3'd0;
    endcase
    return (p < group_size(g)) ? p : 3'd0;
  endfunction

  assign advance    = !out_valid || !out_stall;
  assign size       = group_size(grp);
  assign group_done = (slot == size - 3'd1);
  assign first_grp  = first_group(q_rdata);
  assign q_pop      = (state == ST_IDLE) && !q_status.empty;
  assign color      = rom_color(grp, w);

  // Find the next enabled group after the current one
  always_comb begin
    nxt_found = 1'b0;
    nxt_grp   = GRP_BLINK;
    for (int k = 5; k >= 0; k--) begin
      if ((3'(k) > grp) && group_en(mask, group_t'(3'(k)))) begin
        nxt_found = 1'b1;
        nxt_grp   = group_t'(3'(k));
      end
    end
  end

  // Turn the blink step at the ends of the wave, then step the level
  assign step_n  = ((blink_level == 8'd0) || (blink_level == BLINK_TOP)) ?
                   8'(8'd0 - blink_step) : blink_step;
  assign level_n = 8'(blink_level + step_n);

  // Sequence the writes and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      slime_phase     <= '0;
      shore_phase     <= '0;
      slow_fire_phase <= '0;
      fast_fire_phase <= '0;
      monitor_phase   <= '0;
      blink_level     <= '0;
      blink_step      <= BLINK_STEP_RESET;
    end else begin
      // Raise valid for a new write, drop it once the last one is taken
      if (advance) begin
        out_valid <= (state == ST_EMIT);
      end
      case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            state <= ST_EMIT;
            mask  <= q_rdata;
            grp   <= first_grp;
            slot  <= 3'd0;
            w     <= start_slot(first_grp, slime_phase, shore_phase,
                                slow_fire_phase, fast_fire_phase, monitor_phase);
          end
        end
        ST_EMIT: begin
          if (advance) begin
            palette_index <= group_top(grp) - {5'd0, slot};
            last          <= group_done && !nxt_found;
            if (grp == GRP_BLINK) begin
              red         <= level_n;
              green       <= 8'd0;
              blue        <= 8'd0;
              blink_step  <= step_n;
              blink_level <= level_n;
            end else begin
              red   <= color.red;
              green <= color.green;
              blue  <= color.blue;
            end
            if (group_done) begin
              // Rotate the finished group by one color
              case (grp)
                GRP_SLIME:     slime_phase <= 2'(wrap_next({1'b0, slime_phase}, size));
                GRP_SHORE:     shore_phase <= wrap_next(shore_phase, size);
                GRP_SLOW_FIRE: slow_fire_phase <= wrap_next(slow_fire_phase, size);
                GRP_FAST_FIRE: fast_fire_phase <= wrap_next(fast_fire_phase, size);
                GRP_MONITOR:   monitor_phase <= wrap_next(monitor_phase, size);
                default:       ;
              endcase
              if (nxt_found) begin
                grp  <= nxt_grp;
                slot <= 3'd0;
                w    <= start_slot(nxt_grp, slime_phase, shore_phase,
                                   slow_fire_phase, fast_fire_phase, monitor_phase);
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              slot <= slot + 3'd1;
              w    <= wrap_next(w, size);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/palette_color_cycler_core.sv
// Top level of the palette color cycler: timer front, mask queue and write sequencer.
// Each time transaction is taken while the four-entry due queue has room; the
// front compares the elapsed time of four timers (slow, medium, fast, blink) to
// their period registers and queues a mask of the timers that fired. A
// transaction where no timer fires produces no write. The sequencer pops and loads
// one mask, then emits one palette write per cycle while the output is not
// stalled (4 + 6 + 5 for the slow timer, 5 for medium, 5 for fast, 1 for blink),
// so one transaction gives at most 26 writes. The final write of a transaction
// carries last. Period registers are to be written only while the block is idle;
// the block itself does not enforce this.
module palette_color_cycler_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  palette_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last
);
  import palcc_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  due_t      q_wdata;
  due_t      q_rdata;

  palcc_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .now_time  (now_time),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  palcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  palcc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .palette_index (palette_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last          (last)
  );

`ifndef NO_ASSERTIONS
  // Every write lands in the cycled part of the palette
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((palette_index >= INDEX_LOW) && (palette_index <= INDEX_HIGH)))
    else $error("palette write outside the cycled entries");

  // The blinking entry carries red only
  a_blink_red_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (palette_index == INDEX_HIGH)) |-> ((green == 8'd0) && (blue == 8'd0)))
    else $error("blink write with green or blue set");

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("due mask pushed into a full queue");

  // A popped mask always names at least one timer
  a_pop_nonzero: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_rdata != '0))
    else $error("empty due mask reached the sequencer");
`endif

endmodule
